>>> src/positional_ordered_list_defines.svh
// Assertion macros used by the list controller.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define POL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pol_pkg.sv
package pol_pkg;

  localparam int DefCapacity = 16;

  // Operation codes of an input item.
  localparam logic [3:0] OP_INS_FRONT = 4'd0;
  localparam logic [3:0] OP_INS_BACK  = 4'd1;
  localparam logic [3:0] OP_INS_AT    = 4'd2;
  localparam logic [3:0] OP_DEL_FIRST = 4'd3;
  localparam logic [3:0] OP_DEL_LAST  = 4'd4;
  localparam logic [3:0] OP_DEL_AT    = 4'd5;
  localparam logic [3:0] OP_READ_ALL  = 4'd6;
  localparam logic [3:0] OP_UPDATE    = 4'd7;
  localparam logic [3:0] OP_CLEAR     = 4'd8;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
    logic signed [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic               last;
    logic [4:0]         count;
  } out_item_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT,
    CELL_CMP,
    CELL_WR
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  idx;
    logic [7:0]  tail;
    logic [31:0] value;
    logic [31:0] new_value;
  } cell_cmd_t;

endpackage

>>> src/pol_cell.sv
module pol_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pol_pkg::cell_cmd_t cmd,
  input  logic [31:0]       left_val,
  input  logic [31:0]       right_val,
  input  logic [31:0]       wrap_val,
  input  logic              sel,
  output logic [31:0]       val,
  output logic              match
);
  import pol_pkg::*;

  localparam logic [7:0] MyIdx = 8'(IDX);

  logic [31:0] val_r, val_nxt;
  logic        match_r, match_nxt;

  always_comb begin
    val_nxt   = val_r;
    match_nxt = match_r;
    case (cmd.op)
      CELL_INS: begin
        if (MyIdx > cmd.idx) begin
          val_nxt = left_val;
        end else if (MyIdx == cmd.idx) begin
          val_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= cmd.idx) begin
          val_nxt = right_val;
        end
      end
      CELL_ROT: begin
        // The element at the head wraps around to the tail of the live list.
        if (MyIdx == cmd.tail) begin
          val_nxt = wrap_val;
        end else if (MyIdx < cmd.tail) begin
          val_nxt = right_val;
        end
      end
      CELL_CMP: begin
        match_nxt = (MyIdx <= cmd.tail) && (val_r == cmd.value);
      end
      CELL_WR: begin
        if (sel) begin
          val_nxt = cmd.new_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    match_r <= match_nxt;
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

>>> src/pol_ctrl.sv
`include "positional_ordered_list_defines.svh"

module pol_ctrl #(
  parameter int CAPACITY = pol_pkg::DefCapacity
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pol_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pol_pkg::out_item_t out_item,
  input  logic [31:0]        head_val,
  input  logic [CAPACITY-1:0] match_vec,
  output logic [CAPACITY-1:0] sel_vec,
  output pol_pkg::cell_cmd_t cmd
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPD
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [31:0] nval_r, nval_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        full;
  logic        empty;
  logic [8:0]  pos9;
  logic [8:0]  cnt9;
  logic [7:0]  pos_m1;
  logic        rd_last;

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos9    = {1'b0, in_item.position};
  assign cnt9    = 9'(count_r);
  assign pos_m1  = in_item.position - 8'd1;
  assign rd_last = (rd_r == count_r - CW'(1));

  // First set bit of the registered match flags.
  assign sel_vec = match_vec & (~match_vec + CAPACITY'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_nxt        = rd_r;
    nval_nxt      = nval_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    cmd.op        = CELL_HOLD;
    cmd.idx       = '0;
    cmd.tail      = 8'(count_r) - 8'd1;
    cmd.value     = in_item.value;
    cmd.new_value = nval_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_OK;
          out_item_nxt.data   = '0;
          out_item_nxt.last   = 1'b1;
          case (in_item.operation)
            OP_INS_FRONT: begin
              if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cmd.op    = CELL_INS;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_BACK: begin
              if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cmd.op    = CELL_INS;
                cmd.idx   = 8'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_AT: begin
              if (in_item.position == 8'd0) begin
                out_item_nxt.status = ST_BADPOS;
              end else if (pos9 > cnt9 + 9'd1) begin
                out_item_nxt.status = ST_RANGE;
              end else if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cmd.op    = CELL_INS;
                cmd.idx   = pos_m1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_DEL_FIRST: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                cmd.op    = CELL_DEL;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DEL_LAST: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                cmd.op    = CELL_DEL;
                cmd.idx   = 8'(count_r) - 8'd1;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DEL_AT: begin
              if (in_item.position == 8'd0) begin
                out_item_nxt.status = ST_BADPOS;
              end else if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else if (pos9 > cnt9) begin
                out_item_nxt.status = ST_RANGE;
              end else begin
                cmd.op    = CELL_DEL;
                cmd.idx   = pos_m1;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_nxt        = '0;
                state_nxt     = S_READ;
              end
            end
            OP_UPDATE: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                cmd.op        = CELL_CMP;
                nval_nxt      = in_item.new_value;
                state_nxt     = S_UPD;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              out_item_nxt.status = ST_RANGE;
            end
          endcase
        end
      end
      S_READ: begin
        // The chain rotates once per cycle, so the head cell shows each element
        // in turn and the list is back in order after the last one.
        cmd.op              = CELL_ROT;
        out_valid_nxt       = 1'b1;
        out_item_nxt.status = ST_OK;
        out_item_nxt.data   = head_val;
        out_item_nxt.last   = rd_last;
        rd_nxt              = rd_r + CW'(1);
        if (rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_UPD: begin
        cmd.op              = CELL_WR;
        out_valid_nxt       = 1'b1;
        out_item_nxt.status = (match_vec != '0) ? ST_OK : ST_NOTFOUND;
        out_item_nxt.data   = '0;
        out_item_nxt.last   = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_item_nxt.count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    nval_r     <= nval_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `POL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `POL_ASSERT_NOW(a_read_nonempty, state_r == S_READ, count_r != '0, "read-out of empty list")
  `POL_ASSERT_NOW(a_sel_single, state_r == S_UPD, $onehot0(sel_vec), "update selects several cells")
  `POL_ASSERT_NOW(a_last_idle, out_valid_r && out_item_r.last, state_r == S_IDLE,
                  "final result while still busy")
  `POL_ASSERT_NEXT(a_upd_result, state_r == S_UPD, out_valid_r && out_item_r.last,
                   "update gave no result")

endmodule

>>> src/positional_ordered_list.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells,
// one value per cell, packed from the head. Inserts, deletes and clears never
// raise busy; the result strobe comes in the cycle after start.
// Update compares in every cell, then writes the first match.
// Read-all of a list of N elements emits N results, the chain rotating one
// place per cycle past the head cell.
// Results cannot be held off: out_valid is high for exactly one cycle per result.
module positional_ordered_list #(
  parameter int CAPACITY = pol_pkg::DefCapacity
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pol_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pol_pkg::out_item_t out_item
);
  import pol_pkg::*;

  cell_cmd_t            cmd;
  logic [31:0]          vals [CAPACITY];
  logic [CAPACITY-1:0]  match_vec;
  logic [CAPACITY-1:0]  sel_vec;

  pol_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .head_val (vals[0]),
    .match_vec(match_vec),
    .sel_vec  (sel_vec),
    .cmd      (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_val;
    logic [31:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    pol_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .left_val (left_val),
      .right_val(right_val),
      .wrap_val (vals[0]),
      .sel      (sel_vec[i]),
      .val      (vals[i]),
      .match    (match_vec[i])
    );
  end

endmodule

>>> sim/positional_ordered_list_test.sv
`timescale 1ns / 1ps

module positional_ordered_list_test;
  import pol_pkg::*;

  localparam int Cap = DefCapacity;
  localparam int RandomOps = 405;
  // Operation codes the block treats as unknown.
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_t;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } queued_op_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;

  queued_op_t op_queue[$];
  out_item_t  pending_results[$];

  // Shadow copy of the list contents.
  logic signed [31:0] list_vals[Cap];
  int unsigned        list_len = 0;

  logic        took = 1'b0;
  int unsigned idle_left = 0;
  queued_op_t  drv_next;
  bit          burst_mode = 1'b0;

  int unsigned mismatches = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_full_hits = 0;
  int unsigned n_reads = 0;
  int unsigned peak_len = 0;

  positional_ordered_list #(.CAPACITY(Cap)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [2:0] put_at(int unsigned pos, logic signed [31:0] v);
    if (list_len >= Cap) return ST_FULL;
    for (int i = list_len; i >= int'(pos); i--) list_vals[i] = list_vals[i - 1];
    list_vals[pos - 1] = v;
    list_len++;
    return ST_OK;
  endfunction

  function automatic void take_at(int unsigned pos);
    for (int unsigned i = pos; i < list_len; i++) list_vals[i - 1] = list_vals[i];
    list_len--;
  endfunction

  // Applies one operation to the shadow list and queues the results it causes.
  function automatic void apply_list_op(in_item_t it);
    logic [2:0] st;
    out_item_t  r;
    bit         streamed;
    st = ST_OK;
    streamed = 1'b0;
    case (it.operation)
      OP_INS_FRONT: st = put_at(1, it.value);
      OP_INS_BACK:  st = put_at(list_len + 1, it.value);
      OP_INS_AT: begin
        if (it.position == 0) st = ST_BADPOS;
        else if (it.position > list_len + 1) st = ST_RANGE;
        else st = put_at(it.position, it.value);
      end
      OP_DEL_FIRST: begin
        if (list_len == 0) st = ST_EMPTY;
        else take_at(1);
      end
      OP_DEL_LAST: begin
        if (list_len == 0) st = ST_EMPTY;
        else take_at(list_len);
      end
      OP_DEL_AT: begin
        if (it.position == 0) st = ST_BADPOS;
        else if (list_len == 0) st = ST_EMPTY;
        else if (it.position > list_len) st = ST_RANGE;
        else take_at(it.position);
      end
      OP_READ_ALL: begin
        n_reads++;
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          streamed = 1'b1;
          for (int unsigned i = 0; i < list_len; i++) begin
            r.status = ST_OK;
            r.data = list_vals[i];
            r.last = (i + 1 == list_len);
            r.count = 5'(list_len);
            pending_results.push_back(r);
          end
        end
      end
      OP_UPDATE: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          st = ST_NOTFOUND;
          for (int unsigned i = 0; i < list_len; i++) begin
            if (list_vals[i] == it.value) begin
              list_vals[i] = it.new_value;
              st = ST_OK;
              break;
            end
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: st = ST_RANGE;
    endcase
    if (st == ST_FULL) n_full_hits++;
    if (list_len > peak_len) peak_len = list_len;
    if (!streamed) begin
      r.status = st;
      r.data = '0;
      r.last = 1'b1;
      r.count = 5'(list_len);
      pending_results.push_back(r);
    end
  endfunction

  // Checks the result strobe first, then records an accepted item.
  always @(posedge clk) begin
    took <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d data=%0d last=%0b count=%0d",
                   $realtime, out_item.status, out_item.data, out_item.last,
                   out_item.count);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item.status !== want.status || out_item.data !== want.data ||
            out_item.last !== want.last || out_item.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch: expected status=%0d data=%0d last=%0b count=%0d,",
                     $realtime, want.status, want.data, want.last, want.count,
                     " got status=%0d data=%0d last=%0b count=%0d",
                     out_item.status, out_item.data, out_item.last, out_item.count);
        end
      end
    end
    if (rst_n && start && !busy) begin
      n_items++;
      apply_list_op(in_item);
    end
  end

  // The gap attached to an item is the number of idle cycles after it.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (idle_left != 0 || op_queue.size() == 0) begin
        start <= 1'b0;
        if (idle_left != 0) idle_left <= idle_left - 1;
      end else begin
        drv_next = op_queue.pop_front();
        in_item <= drv_next.item;
        idle_left <= drv_next.gap;
        start <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic in_item_t make_op(logic [3:0] op, logic signed [31:0] v,
                                       logic [7:0] pos, logic signed [31:0] nv);
    in_item_t it;
    it.operation = op;
    it.value = v;
    it.position = pos;
    it.new_value = nv;
    return it;
  endfunction

  function automatic void queue_op(in_item_t it);
    queued_op_t q;
    q.item = it;
    q.gap = pick_gap();
    op_queue.push_back(q);
  endfunction

  // Small values make duplicates likely; copies of held elements make updates hit.
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom;
    if (r < 65) return $urandom_range(7);
    if (r < 80) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    if (list_len == 0) return $urandom;
    return list_vals[$urandom_range(list_len - 1)];
  endfunction

  function automatic logic [7:0] pick_position();
    int unsigned r;
    int unsigned hi;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(list_len + 1, 1));
    if (r < 80) return 8'd0;
    if (r < 90) begin
      hi = list_len + 4;
      return 8'($urandom_range(hi, list_len + 2));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic in_item_t pick_op(traffic_mode_t mode);
    int unsigned ins_w;
    int unsigned del_w;
    int unsigned r;
    logic [3:0]  op;
    case (mode)
      MODE_FILL: begin ins_w = 65; del_w = 12; end
      MODE_DRAIN: begin ins_w = 20; del_w = 55; end
      default: begin ins_w = 40; del_w = 30; end
    endcase
    r = $urandom_range(99);
    if (r < ins_w) begin
      case ($urandom_range(2))
        0: op = OP_INS_FRONT;
        1: op = OP_INS_BACK;
        default: op = OP_INS_AT;
      endcase
    end else if (r < ins_w + del_w) begin
      case ($urandom_range(2))
        0: op = OP_DEL_FIRST;
        1: op = OP_DEL_LAST;
        default: op = OP_DEL_AT;
      endcase
    end else begin
      r = $urandom_range(99);
      if (r < 60) op = OP_UPDATE;
      else if (r < 85) op = OP_READ_ALL;
      else if (r < 93) op = OP_CLEAR;
      else op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    end
    return make_op(op, pick_value(), pick_position(), pick_value());
  endfunction

  initial begin
    traffic_mode_t mode;
    int unsigned   left_in_mode;
    mode = MODE_FILL;
    left_in_mode = 0;

    // Empty-list corner cases, then the first inserts, deletes, updates, read-alls, clears and unknown codes.
    queue_op(make_op(OP_READ_ALL, 0, 0, 0));
    queue_op(make_op(OP_DEL_FIRST, 0, 0, 0));
    queue_op(make_op(OP_DEL_LAST, 0, 0, 0));
    queue_op(make_op(OP_DEL_AT, 0, 8'd0, 0));
    queue_op(make_op(OP_DEL_AT, 0, 8'd1, 0));
    queue_op(make_op(OP_UPDATE, 0, 0, 5));
    queue_op(make_op(OP_INS_AT, 3, 8'd2, 0));
    queue_op(make_op(OP_INS_AT, 3, 8'd0, 0));
    queue_op(make_op(OP_SPARE_HI, 3, 8'd1, 0));
    queue_op(make_op(OP_INS_FRONT, 32'sh8000_0000, 8'd0, 0));
    queue_op(make_op(OP_INS_BACK, 32'sh7fff_ffff, 8'd255, -1));
    queue_op(make_op(OP_INS_AT, -32'sd1, 8'd2, 0));
    queue_op(make_op(OP_INS_AT, 32'sh7fff_ffff, 8'd4, 0));
    queue_op(make_op(OP_INS_AT, 9, 8'd6, 0));
    queue_op(make_op(OP_DEL_AT, 0, 8'd255, 0));
    // Two equal elements are held here, so only the first one may change.
    queue_op(make_op(OP_UPDATE, 32'sh7fff_ffff, 0, 32'sh5555_5555));
    queue_op(make_op(OP_UPDATE, 12345, 0, 1));
    queue_op(make_op(OP_READ_ALL, 0, 0, 0));
    queue_op(make_op(OP_DEL_AT, 0, 8'd2, 0));
    queue_op(make_op(OP_DEL_FIRST, 0, 0, 0));
    queue_op(make_op(OP_DEL_LAST, 0, 0, 0));
    queue_op(make_op(OP_READ_ALL, 0, 0, 0));
    queue_op(make_op(OP_CLEAR, 0, 0, 0));
    queue_op(make_op(OP_CLEAR, 0, 0, 0));
    queue_op(make_op(OP_SPARE_LO, -1, 8'd255, -1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Refilled at the falling edge so the driver never finds the queue empty.
    for (int n = 0; n < RandomOps; n++) begin
      while (op_queue.size() >= 3) @(negedge clk);
      if (left_in_mode == 0) begin
        mode = traffic_mode_t'($urandom_range(2));
        burst_mode = ($urandom_range(3) == 0);
        left_in_mode = $urandom_range(40, 24);
      end
      left_in_mode--;
      queue_op(pick_op(mode));
    end

    while (op_queue.size() != 0 || start) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d list operations (%0d read-alls) and checked %0d results.",
             n_items, n_reads, n_results);
    $display("Peak length %0d of %0d; inserts refused on a full list: %0d; mismatches: %0d.",
             peak_len, Cap, n_full_hits, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
